@@ src/vtm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtual timer multiplexer package
// Shared opcodes and the per-slot record type.
// ----------------------------------------------------------------------------
package vtm_pkg;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_STOP    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_EXPIRE  = 2'd3;

  typedef struct packed {
    logic [31:0] period;
    logic [15:0] ticks_left;
    logic [16:0] spans_left;
    logic [15:0] rem_ticks;
    logic        periodic;
  } slot_rec_t;

endpackage

@@ src/vtm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vtm_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/virtual_timer_multiplexer.sv @@
`timescale 1ns / 1ps
// A start in milliseconds passes through S_MUL, S_DIV, S_REM, S_FIX and S_SWR before
// its reply, and a start in ticks skips S_MUL; stop and restart give no reply.
// One word is handled at a time. An expiry updates every slot, reports each fired timer,
// reloads periodic ones and schedules the smallest count left, stalling on the output.
// Reset clears the running marks and engine state and sets ticks_per_ms to 33;
// slot entries that were never written read as zero.
// ----------------------------------------------------------------------------
// Virtual timer multiplexer
// Shares one compare timer among a table of one-shot and periodic timers.
// ----------------------------------------------------------------------------
module virtual_timer_multiplexer #(
  parameter int NUM_TIMERS   = 8,
  parameter int COMPARE_SPAN = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] duration_i,
  input  logic        timer_mode_i,
  input  logic        time_unit_i,
  input  logic [2:0]  timer_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  slot_id_o,
  output logic        no_free_slot_o,
  output logic        fired_o,
  output logic        schedule_o,
  output logic        reset_counter_o,
  output logic [15:0] schedule_ticks_o,
  output logic        engine_idle_o,
  output logic        last_o
);
  import vtm_pkg::*;

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [15:0] SPAN = 16'(COMPARE_SPAN);
  localparam logic [31:0] SPAN32 = 32'(COMPARE_SPAN);
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(COMPARE_SPAN));
  localparam int RW = $bits(slot_rec_t);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_MUL   = 13'b0000000000010,
    S_DIV   = 13'b0000000000100,
    S_REM   = 13'b0000000001000,
    S_FIX   = 13'b0000000010000,
    S_SWR   = 13'b0000000100000,
    S_ARD   = 13'b0000001000000,
    S_AWR   = 13'b0000010000000,
    S_FRD   = 13'b0000100000000,
    S_FWR   = 13'b0001000000000,
    S_MRD   = 13'b0010000000000,
    S_MCHK  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e state_q;
  logic [10:0] tpm_q;
  logic [NUM_TIMERS-1:0] run_q, done_q, wr_q;
  logic [15:0] cur_q;
  logic eng_q;
  logic [AW:0] idx_q;
  logic [31:0] per_q;
  logic [31:0] quo_q;
  logic [31:0] rem_q;
  logic per_mode_q;
  logic [AW-1:0] slot_q;
  logic found_q;
  logic [15:0] min_q;
  logic final_q;

  logic ov_q;
  logic [2:0] o_slot_q;
  logic o_nofree_q, o_fired_q, o_sched_q, o_rst_q, o_idle_q, o_last_q;
  logic [15:0] o_ticks_q;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  slot_rec_t ram_wdata, ram_rdata;
  logic [RW-1:0] ram_rbits;

  vtm_ram #(.Width(RW), .Depth(NUM_TIMERS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  // Lowest free slot.
  logic [AW-1:0] free_idx;
  logic          free_ok;
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!run_q[i]) begin
        free_idx = AW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  logic [AW-1:0] idx;
  assign idx = idx_q[AW-1:0];
  logic idx_end;
  assign idx_end = (idx_q == (AW+1)'(NUM_TIMERS - 1));

  // Entries that were never written read as an all-zero record.
  assign ram_rdata = wr_q[idx] ? slot_rec_t'(ram_rbits) : '0;

  // Division by the span: a reciprocal multiply gives the quotient or one
  // less, and a single compare and subtract corrects it.
  logic [63:0] recip_prod;
  assign recip_prod = 64'(per_q) * 64'(RECIP);
  logic [31:0] qspan;
  assign qspan = quo_q * SPAN32;

  // Reload values for a period (used after the divide, or after expiry).
  logic [15:0] load_ticks;
  assign load_ticks = (quo_q == '0) ? rem_q[15:0] : SPAN;

  slot_rec_t upd;
  logic      upd_done;
  always_comb begin
    upd = ram_rdata;
    upd_done = 1'b0;
    if (cur_q >= ram_rdata.ticks_left) begin
      if (ram_rdata.spans_left == '0) begin
        upd_done = 1'b1;
      end else begin
        upd.spans_left = ram_rdata.spans_left - 17'd1;
        upd.ticks_left = (upd.spans_left == '0) ? ram_rdata.rem_ticks : SPAN;
      end
    end else begin
      upd.ticks_left = ram_rdata.ticks_left - cur_q;
    end
  end

  logic accept_in;
  assign in_ready_o = (state_q == S_IDLE) && !ov_q;
  assign accept_in  = in_valid_i && in_ready_o;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_raddr = idx;
    ram_wdata = ram_rdata;
    case (state_q)
      S_SWR: begin
        ram_we = 1'b1;
        ram_wdata.period = per_q;
        ram_wdata.spans_left = quo_q[16:0];
        ram_wdata.ticks_left = load_ticks;
        ram_wdata.rem_ticks = rem_q[15:0];
        ram_wdata.periodic = per_mode_q;
      end
      S_AWR: begin
        ram_we = run_q[idx];
        ram_waddr = idx;
        ram_wdata = upd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tpm_q   <= 11'd33;
      run_q   <= '0;
      done_q  <= '0;
      wr_q    <= '0;
      cur_q   <= '0;
      eng_q   <= 1'b0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
      final_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tpm_q <= cfg_wdata_i;
      end
      if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept_in) begin
            case (opcode_i)
              OP_START: begin
                if (!free_ok) begin
                  ov_q <= 1'b1;
                  o_slot_q <= '0; o_nofree_q <= 1'b1; o_fired_q <= 1'b0;
                  o_sched_q <= 1'b0; o_rst_q <= 1'b0; o_ticks_q <= '0;
                  o_idle_q <= 1'b0; o_last_q <= 1'b1;
                end else begin
                  slot_q <= free_idx;
                  per_mode_q <= timer_mode_i;
                  per_q <= duration_i;
                  state_q <= time_unit_i ? S_DIV : S_MUL;
                  rem_q <= '0;
                  quo_q <= '0;
                end
              end
              OP_STOP, OP_RESTART: begin
                if (32'(timer_id_i) < 32'(NUM_TIMERS)) begin
                  run_q[timer_id_i[AW-1:0]] <= (opcode_i == OP_RESTART);
                end
              end
              OP_EXPIRE: begin
                idx_q <= '0;
                done_q <= '0;
                state_q <= S_ARD;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          per_q <= 32'(per_q * {21'd0, tpm_q});
          state_q <= S_DIV;
        end
        S_DIV: begin
          quo_q <= recip_prod[63:32];
          state_q <= S_REM;
        end
        S_REM: begin
          rem_q <= per_q - qspan;
          state_q <= S_FIX;
        end
        S_FIX: begin
          if (rem_q >= SPAN32) begin
            quo_q <= quo_q + 32'd1;
            rem_q <= rem_q - SPAN32;
          end
          state_q <= S_SWR;
        end
        S_SWR: begin
          run_q[slot_q] <= 1'b1;
          wr_q[slot_q] <= 1'b1;
          ov_q <= 1'b1;
          o_slot_q <= 3'(slot_q); o_nofree_q <= 1'b0; o_fired_q <= 1'b0;
          o_idle_q <= 1'b0; o_last_q <= 1'b1;
          if (!eng_q || load_ticks < cur_q) begin
            cur_q <= load_ticks;
            o_sched_q <= 1'b1;
            o_rst_q <= !eng_q;
            o_ticks_q <= load_ticks;
          end else begin
            o_sched_q <= 1'b0; o_rst_q <= 1'b0; o_ticks_q <= '0;
          end
          eng_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_ARD: state_q <= S_AWR;
        S_AWR: begin
          if (run_q[idx]) wr_q[idx] <= 1'b1;
          if (run_q[idx] && upd_done) done_q[idx] <= 1'b1;
          idx_q <= idx_q + 1'b1;
          if (idx_end) begin
            idx_q <= '0;
            state_q <= S_FRD;
          end else begin
            state_q <= S_ARD;
          end
        end
        S_FRD: begin
          if (!ov_q || out_ready_i) begin
            if (done_q[idx]) begin
              ov_q <= 1'b1;
              o_slot_q <= 3'(idx); o_nofree_q <= 1'b0; o_fired_q <= 1'b1;
              o_sched_q <= 1'b0; o_rst_q <= 1'b0; o_ticks_q <= '0;
              o_idle_q <= 1'b0; o_last_q <= 1'b0;
              state_q <= S_FWR;
            end else if (idx_end) begin
              idx_q <= '0;
              found_q <= 1'b0;
              state_q <= S_MRD;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_FWR: begin
          // Periodic reload: the read data gives the period; redo the split.
          done_q[idx] <= 1'b0;
          if (ram_rdata.periodic) begin
            slot_q <= idx;
            per_q <= ram_rdata.period;
            per_mode_q <= 1'b1;
            rem_q <= '0; quo_q <= '0;
            final_q <= 1'b1;
            state_q <= S_DIV;
          end else begin
            run_q[idx] <= 1'b0;
            state_q <= S_FRD;
          end
        end
        S_MRD: state_q <= S_MCHK;
        S_MCHK: begin
          if (run_q[idx] && (!found_q || ram_rdata.ticks_left < min_q)) begin
            min_q <= ram_rdata.ticks_left;
            found_q <= 1'b1;
          end
          if (idx_end) begin
            state_q <= S_OUT;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_MRD;
          end
        end
        S_OUT: begin
          if (!ov_q || out_ready_i) begin
            ov_q <= 1'b1;
            o_slot_q <= '0; o_nofree_q <= 1'b0; o_fired_q <= 1'b0;
            o_rst_q <= 1'b0; o_last_q <= 1'b1;
            o_sched_q <= found_q;
            o_ticks_q <= found_q ? min_q : '0;
            o_idle_q <= !found_q;
            if (found_q) cur_q <= min_q; else eng_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // A reload write returns to the fire scan instead of replying.
      if (state_q == S_SWR && final_q) begin
        final_q <= 1'b0;
        ov_q <= ov_q && !out_ready_i;
        cur_q <= cur_q;
        eng_q <= eng_q;
        o_slot_q <= o_slot_q; o_fired_q <= o_fired_q; o_sched_q <= o_sched_q;
        o_rst_q <= o_rst_q; o_ticks_q <= o_ticks_q; o_idle_q <= o_idle_q;
        o_last_q <= o_last_q; o_nofree_q <= o_nofree_q;
        state_q <= S_FRD;
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign slot_id_o        = o_slot_q;
  assign no_free_slot_o   = o_nofree_q;
  assign fired_o          = o_fired_q;
  assign schedule_o       = o_sched_q;
  assign reset_counter_o  = o_rst_q;
  assign schedule_ticks_o = o_ticks_q;
  assign engine_idle_o    = o_idle_q;
  assign last_o           = o_last_q;

endmodule
